[design/wtcm_pkg.sv]
// ----------------------------------------------------------------------------
// wtcm_pkg
// Shared types and constants of the wall texture column mapper: field widths,
// fixed point layout, register indexes, sequencer states and divider handshake.
// ----------------------------------------------------------------------------
package wtcm_pkg;

  // fixed point and coordinate layout
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned POS_BITS     = 40;
  localparam int unsigned TEX_LOG2_MAX = 10;
  localparam int unsigned TEX_COL_W    = 10;

  // step divider: dividend is 1 << (log2 + FRAC_BITS), at most 27 bits
  localparam int unsigned DIV_BITS  = TEX_LOG2_MAX + FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
  localparam int unsigned STEP_W    = DIV_BITS;
  localparam int unsigned WH_W      = 16;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 28;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // stream widths
  localparam int unsigned S_TDATA_W = 168;
  localparam int unsigned M_TDATA_W = 80;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // action codes carried in the slave tuser
  localparam logic ACT_COLUMN = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  // wall side codes
  localparam logic [1:0] SIDE_EAST  = 2'd0;
  localparam logic [1:0] SIDE_WEST  = 2'd1;
  localparam logic [1:0] SIDE_SOUTH = 2'd2;
  localparam logic [1:0] SIDE_NORTH = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_SIZE_LOG2       = 3'd0,
    CFG_SCREEN_HEIGHT       = 3'd1,
    CFG_IMAGE_ROW_BYTES     = 3'd2,
    CFG_IMAGE_PIXEL_BYTES   = 3'd3,
    CFG_TEXTURE_ROW_BYTES   = 3'd4,
    CFG_TEXTURE_PIXEL_BYTES = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_MUL,
    ST_COL_FRAC,
    ST_COL_DIV,
    ST_COL_KMUL,
    ST_COL_POS,
    ST_PIX_ROW,
    ST_PIX_COL,
    ST_PIX_TROW,
    ST_PIX_TCOL,
    ST_PIX_SUM,
    ST_PIX_OUT
  } state_e;

  // divider request and status
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] shift;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // texture size log2 clamped to the largest supported texture
  function automatic logic [3:0] tex_log2_sat(input logic [3:0] lg);
    logic [3:0] res;
    res = (lg > 4'(TEX_LOG2_MAX)) ? 4'(TEX_LOG2_MAX) : lg;
    return res;
  endfunction

endpackage

[design/wtcm_mul.sv]
// ----------------------------------------------------------------------------
// wtcm_mul
// Shared signed multiplier with a registered product, reused by the sequencer
// for the hit offset, the start position and all byte offset terms.
// ----------------------------------------------------------------------------
module wtcm_mul (
  input  logic                                     clk_i,
  input  logic signed [wtcm_pkg::MUL_A_W-1:0]      a_i,
  input  logic signed [wtcm_pkg::MUL_B_W-1:0]      b_i,
  output logic signed [wtcm_pkg::MUL_P_W-1:0]      prod_o
);

  logic signed [wtcm_pkg::MUL_P_W-1:0] prod_q;
  logic signed [wtcm_pkg::MUL_P_W-1:0] prod_d;

  // full width signed product
  always_comb begin
    prod_d = a_i * b_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

[design/wtcm_div.sv]
// ----------------------------------------------------------------------------
// wtcm_div
// Restoring divider, one quotient bit per cycle, for the texture step:
// (1 << shift) divided by a 16-bit divisor.
// ----------------------------------------------------------------------------
module wtcm_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wtcm_pkg::div_req_t                    req_i,
  input  logic [wtcm_pkg::WH_W-1:0]             divisor_i,
  output wtcm_pkg::div_stat_t                   stat_o,
  output logic [wtcm_pkg::DIV_BITS-1:0]         quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [wtcm_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [wtcm_pkg::DIV_CNT_W-1:0]    shift_q;
  logic [wtcm_pkg::WH_W-1:0]         divisor_q;
  logic [wtcm_pkg::WH_W-1:0]         rem_q, rem_d;
  logic [wtcm_pkg::DIV_BITS-1:0]     quo_q, quo_d;
  logic [wtcm_pkg::WH_W:0]           trial;
  logic [wtcm_pkg::WH_W:0]           diff;
  logic                              fits;

  // one restoring step: bring down the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, (cnt_q == shift_q)};
    diff  = trial - {1'b0, divisor_q};
    fits  = (trial >= {1'b0, divisor_q});
    rem_d = fits ? diff[wtcm_pkg::WH_W-1:0] : trial[wtcm_pkg::WH_W-1:0];
    quo_d = {quo_q[wtcm_pkg::DIV_BITS-2:0], fits};
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = wtcm_pkg::DIV_CNT_W'(wtcm_pkg::DIV_BITS - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      shift_q   <= req_i.shift;
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[design/wall_texture_column_mapper.sv]
// ----------------------------------------------------------------------------
// wall_texture_column_mapper
// Texture coordinate and byte offset generator for one raycaster wall column.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream: tuser = action (0 loads a column descriptor, 1 is a pixel
//   tick), tdata = the column descriptor. Column beats give no output; a
//   pixel tick with a column loaded gives one master beat with the image and
//   texel byte offsets, tuser = texture select, tlast on the span's last row.
//   cfg channel: writes one register per beat (index, data), always ready;
//   write only while no item is in progress.
// Timing:
//   a column beat keeps tready low through the hit offset multiply and the
//   texel column, the wait on the bit-serial step divider (27 quotient bits
//   and its done flag) and the start position multiply, so no new beat is
//   taken until the column is loaded. A pixel tick raises tvalid after four
//   passes through the one shared multiplier plus the sums and a registered
//   output; a new tick is taken only once the last one is in the output
//   register. tready is high only while the sequencer is idle.
// Reset: control, configuration and column registers take their default values, no column is loaded.
// Stall: a finished beat waits in the output register; the block still takes
//   the next item, and a following tick waits at its last step for space.
// ----------------------------------------------------------------------------
module wall_texture_column_mapper (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: column[11:0], wall_side[13:12], pos_x[37:14], pos_y[61:38],
  // ray_x[79:62], ray_y[97:80], distance[121:98], span_top[133:122],
  // span_bottom[145:134], wall_height[161:146], zero pad[167:162]
  input  logic [wtcm_pkg::S_TDATA_W-1:0]        s_axis_tdata_i,
  // tuser: action[0]
  input  logic                                  s_axis_tuser_i,
  // master stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata: image_offset[31:0], texel_offset[63:32], pixel_row[75:64],
  // zero pad[79:76]
  output logic [wtcm_pkg::M_TDATA_W-1:0]        m_axis_tdata_o,
  // tuser: texture_select[1:0]
  output logic [1:0]                            m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wtcm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wtcm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // configuration registers
  logic [3:0]  cfg_tex_log2_q;
  logic [11:0] cfg_screen_height_q;
  logic [15:0] cfg_image_row_bytes_q;
  logic [3:0]  cfg_image_pixel_bytes_q;
  logic [15:0] cfg_texture_row_bytes_q;
  logic [3:0]  cfg_texture_pixel_bytes_q;

  // sequencer and column state
  wtcm_pkg::state_e state_q, state_d;
  logic                                 active_q;
  logic [11:0]                          cur_column_q;
  logic [1:0]                           cur_side_q;
  logic [11:0]                          cur_row_q;
  logic [11:0]                          end_row_q;
  logic [wtcm_pkg::TEX_COL_W-1:0]       texel_col_q;
  logic [wtcm_pkg::STEP_W-1:0]          step_q;
  logic [wtcm_pkg::POS_BITS-1:0]        tex_pos_q;

  // column load temporaries
  logic [23:0]                          dist_q;
  logic [17:0]                          ray_q;
  logic [15:0]                          posf_q;
  logic [wtcm_pkg::WH_W-1:0]            wh_q;
  logic [17:0]                          k_q;
  logic                                 mirror_q;
  logic                                 span_ok_q;

  // pixel tick temporaries
  logic [wtcm_pkg::TEX_COL_W-1:0]       trow_q;
  logic [31:0]                          acc_q;
  logic [31:0]                          img_q;
  logic [31:0]                          tex_q;

  // output register
  logic                                 m_valid_q;
  logic [wtcm_pkg::M_TDATA_W-1:0]       m_data_q;
  logic [1:0]                           m_user_q;
  logic                                 m_last_q;

  // slave field views
  logic [11:0] in_column;
  logic [1:0]  in_side;
  logic [23:0] in_pos_x;
  logic [23:0] in_pos_y;
  logic [17:0] in_ray_x;
  logic [17:0] in_ray_y;
  logic [23:0] in_distance;
  logic [11:0] in_span_top;
  logic [11:0] in_span_bottom;
  logic [15:0] in_wall_height;

  assign in_column      = s_axis_tdata_i[11:0];
  assign in_side        = s_axis_tdata_i[13:12];
  assign in_pos_x       = s_axis_tdata_i[37:14];
  assign in_pos_y       = s_axis_tdata_i[61:38];
  assign in_ray_x       = s_axis_tdata_i[79:62];
  assign in_ray_y       = s_axis_tdata_i[97:80];
  assign in_distance    = s_axis_tdata_i[121:98];
  assign in_span_top    = s_axis_tdata_i[133:122];
  assign in_span_bottom = s_axis_tdata_i[145:134];
  assign in_wall_height = s_axis_tdata_i[161:146];

  logic s_accept;
  logic col_accept;
  logic pix_accept;
  logic out_free;
  logic out_load;

  assign s_axis_tready_o = (state_q == wtcm_pkg::ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign col_accept      = s_accept && (s_axis_tuser_i == wtcm_pkg::ACT_COLUMN);
  assign pix_accept      = s_accept && (s_axis_tuser_i == wtcm_pkg::ACT_PIXEL) && active_q;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == wtcm_pkg::ST_PIX_OUT) && out_free;
  assign cfg_ready_o     = 1'b1;

  // texture size terms from the current configuration
  logic [3:0]                     lg_eff;
  logic [wtcm_pkg::TEX_COL_W:0]   tsize;
  logic [wtcm_pkg::TEX_COL_W-1:0] tmask;

  always_comb begin
    lg_eff = wtcm_pkg::tex_log2_sat(cfg_tex_log2_q);
    tsize  = (wtcm_pkg::TEX_COL_W+1)'(1) << lg_eff;
    tmask  = wtcm_pkg::TEX_COL_W'(tsize - 1'b1);
  end

  // column descriptor precompute at accept
  logic        side_ew;
  logic        mirror_d;
  logic [17:0] k_d;

  always_comb begin
    side_ew  = (in_side == wtcm_pkg::SIDE_EAST) || (in_side == wtcm_pkg::SIDE_WEST);
    mirror_d = side_ew ? (!in_ray_x[17] && (in_ray_x != '0)) : in_ray_y[17];
    k_d      = {6'd0, in_span_top} - {7'd0, cfg_screen_height_q[11:1]}
             + {3'd0, in_wall_height[15:1]};
  end

  // shared multiplier operand select
  logic signed [wtcm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [wtcm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [wtcm_pkg::MUL_P_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      wtcm_pkg::ST_COL_MUL: begin
        mul_a = {1'b0, dist_q};
        mul_b = {{10{ray_q[17]}}, ray_q};
      end
      wtcm_pkg::ST_COL_KMUL: begin
        mul_a = {{7{k_q[17]}}, k_q};
        mul_b = {1'b0, step_q};
      end
      wtcm_pkg::ST_PIX_ROW: begin
        mul_a = {13'd0, cur_row_q};
        mul_b = {12'd0, cfg_image_row_bytes_q};
      end
      wtcm_pkg::ST_PIX_COL: begin
        mul_a = {13'd0, cur_column_q};
        mul_b = {24'd0, cfg_image_pixel_bytes_q};
      end
      wtcm_pkg::ST_PIX_TROW: begin
        mul_a = {15'd0, trow_q};
        mul_b = {12'd0, cfg_texture_row_bytes_q};
      end
      wtcm_pkg::ST_PIX_TCOL: begin
        mul_a = {15'd0, texel_col_q};
        mul_b = {24'd0, cfg_texture_pixel_bytes_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wtcm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // step divider
  wtcm_pkg::div_req_t           div_req;
  wtcm_pkg::div_stat_t          div_stat;
  logic [wtcm_pkg::DIV_BITS-1:0] div_quo;

  always_comb begin
    div_req.start = (state_q == wtcm_pkg::ST_COL_FRAC);
    div_req.shift = wtcm_pkg::DIV_CNT_W'({1'b0, lg_eff} + 5'(wtcm_pkg::FRAC_BITS));
  end

  wtcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .divisor_i  (wh_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // texel column from the hit fraction, mirrored by side and ray sign
  logic [15:0]                    frac;
  logic [15:0]                    frac_sh;
  logic [wtcm_pkg::TEX_COL_W-1:0] col_raw;
  logic [wtcm_pkg::TEX_COL_W-1:0] col_fin;

  always_comb begin
    frac    = posf_q + prod[31:16];
    frac_sh = frac >> (5'(wtcm_pkg::FRAC_BITS) - {1'b0, lg_eff});
    col_raw = frac_sh[wtcm_pkg::TEX_COL_W-1:0];
    col_fin = mirror_q ? (~col_raw & tmask) : col_raw;
  end

  // texel row: integer part truncated toward zero, masked to the texture
  logic [wtcm_pkg::POS_BITS-1:0]                      pos_neg;
  logic [wtcm_pkg::POS_BITS-wtcm_pkg::FRAC_BITS-1:0]  ipart;
  logic [wtcm_pkg::POS_BITS-wtcm_pkg::FRAC_BITS-1:0]  ipart_neg;
  logic [wtcm_pkg::TEX_COL_W-1:0]                     trow_d;

  always_comb begin
    pos_neg   = -tex_pos_q;
    ipart     = pos_neg[wtcm_pkg::POS_BITS-1:wtcm_pkg::FRAC_BITS];
    ipart_neg = -ipart;
    trow_d    = tex_pos_q[wtcm_pkg::POS_BITS-1]
              ? (ipart_neg[wtcm_pkg::TEX_COL_W-1:0] & tmask)
              : (tex_pos_q[wtcm_pkg::FRAC_BITS +: wtcm_pkg::TEX_COL_W] & tmask);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wtcm_pkg::ST_IDLE: begin
        if (col_accept) begin
          state_d = wtcm_pkg::ST_COL_MUL;
        end else if (pix_accept) begin
          state_d = wtcm_pkg::ST_PIX_ROW;
        end
      end
      wtcm_pkg::ST_COL_MUL:  state_d = wtcm_pkg::ST_COL_FRAC;
      wtcm_pkg::ST_COL_FRAC: state_d = wtcm_pkg::ST_COL_DIV;
      wtcm_pkg::ST_COL_DIV: begin
        if (div_stat.done) begin
          state_d = wtcm_pkg::ST_COL_KMUL;
        end
      end
      wtcm_pkg::ST_COL_KMUL: state_d = wtcm_pkg::ST_COL_POS;
      wtcm_pkg::ST_COL_POS:  state_d = wtcm_pkg::ST_IDLE;
      wtcm_pkg::ST_PIX_ROW:  state_d = wtcm_pkg::ST_PIX_COL;
      wtcm_pkg::ST_PIX_COL:  state_d = wtcm_pkg::ST_PIX_TROW;
      wtcm_pkg::ST_PIX_TROW: state_d = wtcm_pkg::ST_PIX_TCOL;
      wtcm_pkg::ST_PIX_TCOL: state_d = wtcm_pkg::ST_PIX_SUM;
      wtcm_pkg::ST_PIX_SUM:  state_d = wtcm_pkg::ST_PIX_OUT;
      wtcm_pkg::ST_PIX_OUT: begin
        if (out_free) begin
          state_d = wtcm_pkg::ST_IDLE;
        end
      end
      default: state_d = wtcm_pkg::ST_IDLE;
    endcase
  end

  // control state, configuration and column state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                   <= wtcm_pkg::ST_IDLE;
      cfg_tex_log2_q            <= 4'd6;
      cfg_screen_height_q       <= 12'd480;
      cfg_image_row_bytes_q     <= 16'd2560;
      cfg_image_pixel_bytes_q   <= 4'd4;
      cfg_texture_row_bytes_q   <= 16'd256;
      cfg_texture_pixel_bytes_q <= 4'd4;
      active_q                  <= 1'b0;
      cur_column_q              <= '0;
      cur_side_q                <= '0;
      cur_row_q                 <= '0;
      end_row_q                 <= '0;
      texel_col_q               <= '0;
      step_q                    <= '0;
      tex_pos_q                 <= '0;
      m_valid_q                 <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wtcm_pkg::CFG_TEX_SIZE_LOG2:       cfg_tex_log2_q <= cfg_data_i[3:0];
          wtcm_pkg::CFG_SCREEN_HEIGHT:       cfg_screen_height_q <= cfg_data_i[11:0];
          wtcm_pkg::CFG_IMAGE_ROW_BYTES:     cfg_image_row_bytes_q <= cfg_data_i;
          wtcm_pkg::CFG_IMAGE_PIXEL_BYTES:   cfg_image_pixel_bytes_q <= cfg_data_i[3:0];
          wtcm_pkg::CFG_TEXTURE_ROW_BYTES:   cfg_texture_row_bytes_q <= cfg_data_i;
          wtcm_pkg::CFG_TEXTURE_PIXEL_BYTES: cfg_texture_pixel_bytes_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end

      // column descriptor beat
      if (col_accept) begin
        active_q     <= 1'b0;
        cur_column_q <= in_column;
        cur_side_q   <= in_side;
        cur_row_q    <= in_span_top;
        end_row_q    <= in_span_bottom;
      end

      if (state_q == wtcm_pkg::ST_COL_FRAC) begin
        texel_col_q <= col_fin;
      end

      if ((state_q == wtcm_pkg::ST_COL_DIV) && div_stat.done) begin
        step_q <= div_quo;
      end

      if (state_q == wtcm_pkg::ST_COL_POS) begin
        tex_pos_q <= prod[wtcm_pkg::POS_BITS-1:0];
        active_q  <= span_ok_q;
      end

      // pixel beat retires: advance the row
      if (out_load) begin
        tex_pos_q <= tex_pos_q + {{(wtcm_pkg::POS_BITS-wtcm_pkg::STEP_W){1'b0}}, step_q};
        if (cur_row_q == end_row_q) begin
          active_q <= 1'b0;
        end else begin
          cur_row_q <= cur_row_q + 1'b1;
        end
      end

      // output valid
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath temporaries and output payload
  always_ff @(posedge clk_i) begin
    if (col_accept) begin
      dist_q    <= in_distance;
      ray_q     <= side_ew ? in_ray_y : in_ray_x;
      posf_q    <= side_ew ? in_pos_y[15:0] : in_pos_x[15:0];
      wh_q      <= (in_wall_height == '0) ? 16'd1 : in_wall_height;
      k_q       <= k_d;
      mirror_q  <= mirror_d;
      span_ok_q <= (in_span_top <= in_span_bottom);
    end

    if (state_q == wtcm_pkg::ST_PIX_ROW) begin
      trow_q <= trow_d;
    end
    if (state_q == wtcm_pkg::ST_PIX_COL) begin
      acc_q <= prod[31:0];
    end
    if (state_q == wtcm_pkg::ST_PIX_TROW) begin
      img_q <= acc_q + prod[31:0];
    end
    if (state_q == wtcm_pkg::ST_PIX_TCOL) begin
      acc_q <= prod[31:0];
    end
    if (state_q == wtcm_pkg::ST_PIX_SUM) begin
      tex_q <= acc_q + prod[31:0];
    end

    if (out_load) begin
      m_data_q <= {4'd0, cur_row_q, tex_q, img_q};
      m_user_q <= cur_side_q;
      m_last_q <= (cur_row_q == end_row_q);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  // a column beat keeps the slave side closed on the next cycle
  a_col_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_accept |=> !s_axis_tready_o)
    else $error("column beat did not close the slave side");

  // the divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == wtcm_pkg::ST_COL_DIV))
    else $error("divider finished outside the step wait");

  // a finished pixel lands in the output register and the sequencer returns
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid_o && (state_q == wtcm_pkg::ST_IDLE)))
    else $error("pixel beat not presented after its last step");

  // no pixel can be generated while a column is loading
  a_inactive_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtcm_pkg::ST_COL_MUL) |-> !active_q)
    else $error("column still active during load");
`endif

endmodule
